[sv/assert_macros.svh]
// Assertion macros shared by the softmax normalizer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/smx_pkg.sv]
// Package for the softmax normalizer: types, constants, exponent table.
// No dependencies.
`default_nettype none
package smx_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned EXP_W     = 17;
  localparam int unsigned SUM_W     = 23;
  localparam int unsigned LOG2E_Q16 = 94548;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_CALC,
    ST_OUT_RD,
    ST_DIV,
    ST_OUT
  } smx_state_e;

  typedef struct packed {
    logic             load;
    logic             exp_wr;
    logic             div_start;
    logic [IDX_W-1:0] idx;
    logic             clear;
  } smx_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             div_done;
  } smx_stat_t;

  typedef logic [255:0][16:0] frac_tab_t;

  localparam logic [31:0] POW_STEPS [8] = '{
    32'd4283353945, 32'd4271771996, 32'd4248701965, 32'd4202935003,
    32'd4112874793, 32'd3938502376, 32'd3611622603, 32'd3037000500
  };

  function automatic logic [16:0] frac_table(input logic [7:0] f);
    logic [32:0] acc;
    logic [64:0] prod;
    acc = 33'h1_0000_0000;
    for (int k = 0; k < 8; k++) begin
      if (f[k]) begin
        prod = acc * POW_STEPS[k];
        acc  = prod[64:32];
      end
    end
    return acc[32:16];
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = frac_table(8'(i));
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage
`default_nettype wire

[sv/smx_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module smx_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/smx_datapath.sv]
// Datapath: score and exponent stores, max, sum, exponent unit, serial divider.
// Depends on smx_pkg and smx_ram.
`default_nettype none
`include "assert_macros.svh"
module smx_datapath import smx_pkg::*; #(
  parameter int unsigned MAX_N = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire smx_cmd_t          cmd_i,
  input  wire logic signed [15:0] logit_i,
  output      smx_stat_t         stat_o,
  output      logic [EXP_W-1:0]  prob_o,
  output      logic              ovf_o
);
  logic [CNT_W-1:0] count_q, count_d;
  logic signed [15:0] max_q, max_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic ovf_q, ovf_d;
  logic [15:0] score_rd;
  logic [EXP_W-1:0] exp_rd;
  logic [EXP_W-1:0] exp_val;
  logic store_ok;
  logic [16:0] diff;
  logic [33:0] prod;
  logic [17:0] y;
  logic [16:0] tab;
  logic [SUM_W+16:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [5:0] bit_q, bit_d;
  logic busy_q, busy_d;
  logic [SUM_W+16:0] trial;

  assign store_ok = (count_q < CNT_W'(MAX_N));

  smx_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_score (
    .clk_i, .we_i(cmd_i.load && store_ok), .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(logit_i), .raddr_i(cmd_i.idx), .rdata_o(score_rd)
  );

  smx_ram #(.WIDTH(EXP_W), .DEPTH(DEPTH)) u_exp (
    .clk_i, .we_i(cmd_i.exp_wr), .waddr_i(cmd_i.idx),
    .wdata_i(exp_val), .raddr_i(cmd_i.idx), .rdata_o(exp_rd)
  );

  always_comb begin
    diff    = 17'(max_q - $signed(score_rd));
    prod    = diff * 17'(LOG2E_Q16);
    y       = prod[33:16];
    tab     = FRAC_TAB[y[7:0]];
    exp_val = (y[17:8] >= 10'd17) ? '0 : (tab >> y[12:8]);
  end

  always_comb begin
    count_d = count_q;
    max_d   = max_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    if (cmd_i.load) begin
      if (store_ok) begin
        count_d = count_q + 1'b1;
        if (logit_i > max_q) max_d = logit_i;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.exp_wr) sum_d = sum_q + SUM_W'(exp_val);
    if (cmd_i.clear) begin
      count_d = '0;
      max_d   = 16'sh8000;
      sum_d   = '0;
      ovf_d   = 1'b0;
    end
  end

  // restoring division of exp<<16 by sum, one quotient bit a cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    trial  = rem_q - ((SUM_W+17)'(sum_q) << bit_q);
    if (cmd_i.div_start) begin
      rem_d  = (SUM_W+17)'(exp_rd) << 16;
      quo_d  = '0;
      bit_d  = 6'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[SUM_W+16]) begin
        rem_d        = trial;
        quo_d[bit_q[4:0]] = 1'b1;
      end
      if (bit_q == 6'd0) busy_d = 1'b0;
      else bit_d = bit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= 16'sh8000;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      count_q <= count_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.count    = count_q;
  assign stat_o.div_done = busy_q && (bit_q == 6'd0);
  assign prob_o = quo_d;
  assign ovf_o  = ovf_q;

  `ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_N))
  `ASSERT_NEXT(a_clear, cmd_i.clear, count_q == '0 && !ovf_q)
  `ASSERT_IMPL(a_div_idle, cmd_i.div_start, !busy_q)
endmodule
`default_nettype wire

[sv/smx_ctrl.sv]
// Controller: sequences loading, exponent pass, division and emission.
// Depends on smx_pkg.
`default_nettype none
`include "assert_macros.svh"
module smx_ctrl import smx_pkg::*; #(
  parameter int unsigned MAX_N = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire logic      final_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      logic [IDX_W-1:0] out_pos_o,
  output      logic      out_last_o,
  input  wire smx_stat_t stat_i,
  output      smx_cmd_t  cmd_o,
  output      logic      cap_o
);
  smx_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic vld_q, vld_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic last_q, last_d;
  logic is_last;

  assign is_last = (CNT_W'(idx_q) + 1'b1 == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      idx_q   <= '0;
      n_q     <= '0;
      vld_q   <= 1'b0;
      pos_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      vld_q   <= vld_d;
      pos_q   <= pos_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    n_d     = n_q;
    vld_d   = vld_q;
    pos_d   = pos_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    cap_o   = 1'b0;
    in_stall_o = 1'b1;
    if (vld_q && !out_stall_i) vld_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (final_item_i) begin
            n_d     = (stat_i.count < CNT_W'(MAX_N)) ? stat_i.count + 1'b1 : stat_i.count;
            idx_d   = '0;
            state_d = ST_EXP_RD;
          end
        end
      end
      ST_EXP_RD: begin
        state_d = ST_EXP_CALC;
      end
      ST_EXP_CALC: begin
        cmd_o.exp_wr = 1'b1;
        if (is_last) begin
          idx_d   = '0;
          state_d = ST_OUT_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_EXP_RD;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!vld_q || !out_stall_i) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done && !vld_d) begin
          cap_o  = 1'b1;
          vld_d  = 1'b1;
          pos_d  = idx_q;
          last_d = is_last;
          if (is_last) begin
            cmd_o.clear = 1'b1;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign out_valid_o = vld_q;
  assign out_pos_o   = pos_q;
  assign out_last_o  = last_q;

  `ASSERT_IMPL(a_no_load_busy, state_q != ST_LOAD, in_stall_o)
  `ASSERT_NEXT(a_hold_out, vld_q && out_stall_i, vld_q && $stable(pos_q))
  `ASSERT_IMPL(a_n_range, state_q == ST_EXP_CALC, n_q != '0)
endmodule
`default_nettype wire

[sv/softmax_normalizer.sv]
// Top level of the streaming fixed-point softmax normalizer.
// Depends on smx_pkg, smx_ctrl, smx_datapath, smx_ram.
//  channel | dir | handshake             | fields
//  in      | in  | in_valid_i/in_stall_o | logit_i, final_item_i
//  out     | out | out_valid_o/out_stall_i| probability_o, position_o,
//          |     |                       | final_result_o, status_o
// Loading takes one word per cycle while in the load state; the last word starts two passes.
// Exponent pass: each stored score gets a store read, then goes through the exponent unit.
// Output: each probability takes a store read, a divider start and 17 divider steps.
// Reset clears counters and flags; stores need no clearing.
// A stalled output word holds; the next division waits for it to leave.
`default_nettype none
module softmax_normalizer import smx_pkg::*; #(
  parameter int unsigned MAX_N = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] logit_i,
  input  wire logic               final_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [16:0]        probability_o,
  output      logic [5:0]         position_o,
  output      logic               final_result_o,
  output      logic               status_o
);
  smx_cmd_t  cmd;
  smx_stat_t stat;
  logic [EXP_W-1:0] prob;
  logic ovf;
  logic cap;
  logic [EXP_W-1:0] prob_q;
  logic stat_q;

  smx_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .final_item_i,
    .out_valid_o, .out_stall_i, .out_pos_o(position_o),
    .out_last_o(final_result_o), .stat_i(stat), .cmd_o(cmd), .cap_o(cap)
  );

  smx_datapath #(.MAX_N(MAX_N)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .logit_i, .stat_o(stat), .prob_o(prob),
    .ovf_o(ovf)
  );

  always_ff @(posedge clk_i) begin
    if (cap) begin
      prob_q <= prob;
      stat_q <= ovf || (cmd.load && final_item_i && (stat.count >= CNT_W'(MAX_N)));
    end
  end

  assign probability_o = prob_q;
  assign status_o      = stat_q;
endmodule
`default_nettype wire

[tb/sv/softmax_normalizer_test.sv]
// Testbench for softmax_normalizer: streams Q8.8 score vectors, predicts every
// probability word with a local fixed-point softmax and checks the output channel.
// Depends on smx_pkg and the softmax_normalizer RTL.
`timescale 1ns / 100ps
`default_nettype none
module softmax_normalizer_test;
  import smx_pkg::*;

  localparam int unsigned CAP = 64;
  localparam int unsigned CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last;
  } score_word_t;

  typedef struct packed {
    logic [16:0] prob;
    logic [5:0]  pos;
    logic        last;
    logic        trunc;
  } prob_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] logit_i = '0;
  logic final_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [16:0] probability_o;
  logic [5:0] position_o;
  logic final_result_o;
  logic status_o;

  softmax_normalizer #(.MAX_N(CAP)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .logit_i, .final_item_i,
    .out_valid_o, .out_stall_i, .probability_o, .position_o, .final_result_o,
    .status_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  score_word_t pending_scores[$];
  prob_word_t  expected_probs[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          in_taken = 1'b0;

  // vector state of the predictor
  logic signed [15:0] held_scores[CAP];
  int unsigned        held_count = 0;
  logic signed [15:0] peak_score = -16'sd32768;
  bit                 dropped = 1'b0;

  function automatic logic [16:0] two_pow_frac(input logic [7:0] f);
    logic [63:0] acc;
    logic [31:0] steps [8];
    steps = '{32'd4283353945, 32'd4271771996, 32'd4248701965, 32'd4202935003,
              32'd4112874793, 32'd3938502376, 32'd3611622603, 32'd3037000500};
    acc = 64'h1_0000_0000;
    for (int k = 0; k < 8; k++)
      if (f[k]) acc = (acc * steps[k]) >> 32;
    return acc[32:16];
  endfunction

  function automatic logic [16:0] exp_of_gap(input logic signed [15:0] x,
                                             input logic signed [15:0] mx);
    logic [63:0] d, y;
    d = 64'(int'(mx) - int'(x));
    y = (d * 64'd94548) >> 16;
    if ((y >> 8) >= 17) return '0;
    return two_pow_frac(y[7:0]) >> (y >> 8);
  endfunction

  task automatic predict_softmax(input score_word_t w);
    logic [16:0] e [CAP];
    logic [22:0] total;
    prob_word_t  p;
    if (held_count < CAP) begin
      held_scores[held_count] = w.score;
      held_count++;
      if (w.score > peak_score) peak_score = w.score;
    end else dropped = 1'b1;
    if (!w.last) return;
    total = '0;
    for (int i = 0; i < held_count; i++) begin
      e[i] = exp_of_gap(held_scores[i], peak_score);
      total = total + e[i];
    end
    for (int i = 0; i < held_count; i++) begin
      p.prob = 17'(({47'd0, e[i]} << 16) / total);
      p.pos = 6'(i);
      p.last = (i + 1 == held_count);
      p.trunc = dropped;
      expected_probs.push_back(p);
    end
    held_count = 0;
    peak_score = -16'sd32768;
    dropped = 1'b0;
  endtask

  task automatic queue_vector(input int unsigned len, input int kind);
    score_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        0: w.score = 16'($urandom);
        1: w.score = 16'($urandom_range(0, 2047)) - 16'sd1024;
        default: w.score = (i % 2) ? 16'sh7fff : -16'sd32768;
      endcase
      w.last = (i + 1 == len);
      pending_scores.push_back(w);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        predict_softmax(pending_scores.pop_front());
      end
      if (!in_valid_i || in_taken) begin
        if (pending_scores.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          in_valid_i <= 1'b1;
          logit_i <= pending_scores[0].score;
          final_item_i <= pending_scores[0].last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  always @(posedge clk_i) begin
    prob_word_t exp_w;
    cycle_count++;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_probs.size() == 0) begin
        errors++;
        $display("%0t unexpected word prob %0d pos %0d", $time, probability_o, position_o);
      end else begin
        exp_w = expected_probs.pop_front();
        if (probability_o !== exp_w.prob || position_o !== exp_w.pos ||
            final_result_o !== exp_w.last || status_o !== exp_w.trunc) begin
          errors++;
          $display("%0t mismatch: expected prob %0d pos %0d last %0d status %0d, actual %0d %0d %0d %0d",
                   $time, exp_w.prob, exp_w.pos, exp_w.last, exp_w.trunc,
                   probability_o, position_o, final_result_o, status_o);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    score_word_t w;
    // directed: single scores, extremes, ties, underflowed exponents, overflow
    w.last = 1'b1;
    w.score = 16'sh7fff;   pending_scores.push_back(w);
    w.score = -16'sd32768; pending_scores.push_back(w);
    queue_vector(4, 2);
    w.last = 1'b0; w.score = 16'sd0; pending_scores.push_back(w);
    w.last = 1'b1; w.score = 16'sd0; pending_scores.push_back(w);
    w.last = 1'b0; w.score = 16'sd256; pending_scores.push_back(w);
    w.last = 1'b0; w.score = -16'sd1; pending_scores.push_back(w);
    w.last = 1'b1; w.score = -16'sd3000; pending_scores.push_back(w);
    queue_vector(CAP + 3, 1);
    queue_vector(CAP, 0);
    // random vectors, mostly short
    while (pending_scores.size() < 470)
      queue_vector(($urandom_range(0, 9) == 0) ? $urandom_range(50, 70)
                                              : $urandom_range(1, 8),
                   $urandom_range(0, 1));
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (pending_scores.size() < 300);
    calm = 1'b1;
    wait (pending_scores.size() < 200);
    calm = 1'b0;
    wait (pending_scores.size() == 0 && !in_valid_i);
    wait (expected_probs.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_probs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/smx_pkg.sv
sv/smx_ram.sv
sv/smx_datapath.sv
sv/smx_ctrl.sv
sv/softmax_normalizer.sv
tb/sv/softmax_normalizer_test.sv
